### design/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types, codes and the CRC-8 byte update for the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  // configuration register indexes
  localparam logic CFG_FRAME_BYTE  = 1'b0;
  localparam logic CFG_ESCAPE_BYTE = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] FRAME_BYTE_RST  = 8'd254;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'd253;

  // unescape mask and reflected polynomial
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // command carried from the front end to the back end
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } efr_cmd_t;

  // kind of a result transaction
  typedef enum logic {
    ITEM_PAYLOAD = 1'b0,
    ITEM_END     = 1'b1
  } efr_item_t;

  // one queue entry
  typedef struct packed {
    efr_cmd_t   cmd;
    logic [7:0] data;
  } efr_entry_t;

  // one byte of the reflected Maxim CRC-8
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

### design/efr_in_if.sv
// ----------------------------------------------------------------------------
// efr_in_if
// Received line byte channel: valid, ready and one raw byte.
// ----------------------------------------------------------------------------
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/efr_out_if.sv
// ----------------------------------------------------------------------------
// efr_out_if
// Result channel: payload bytes and end of frame markers with the CRC flag.
// ----------------------------------------------------------------------------
interface efr_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic       crc_good;

  modport source (output valid, output item_kind, output payload_byte, output crc_good,
                  input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input crc_good,
                  output ready);
endinterface

### design/efr_front.sv
// ----------------------------------------------------------------------------
// efr_front
// Classifies line bytes into delimiters, escapes and data, unescapes data
// bytes and pushes commands into the queue. Holds the configuration registers.
// ----------------------------------------------------------------------------
module efr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data,
  // line byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  // queue push side
  output logic                  push_valid,
  input  logic                  push_ready,
  output efr_pkg::efr_entry_t   push_entry
);

  logic [7:0] frame_byte_r;
  logic [7:0] escape_byte_r;
  logic       esc_pending_r;
  logic       esc_pending_nxt;
  logic       accept;
  logic       is_frame;
  logic       is_escape;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_byte_r  <= efr_pkg::FRAME_BYTE_RST;
      escape_byte_r <= efr_pkg::ESCAPE_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efr_pkg::CFG_FRAME_BYTE:  frame_byte_r  <= cfg_data;
        efr_pkg::CFG_ESCAPE_BYTE: escape_byte_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte classification, delimiter wins over escape
  assign is_frame  = (in_byte == frame_byte_r);
  assign is_escape = !is_frame && (in_byte == escape_byte_r);
  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;

  // escapes never reach the queue
  assign push_valid = in_valid && !is_escape;

  always_comb begin
    push_entry.cmd  = is_frame ? efr_pkg::CMD_END : efr_pkg::CMD_DATA;
    push_entry.data = esc_pending_r ? (in_byte ^ efr_pkg::ESC_XOR) : in_byte;
  end

  // escape flag: set by an escape, cleared by a data byte, kept over delimiters
  always_comb begin
    esc_pending_nxt = esc_pending_r;
    if (accept) begin
      if (is_escape) begin
        esc_pending_nxt = 1'b1;
      end else if (!is_frame) begin
        esc_pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pending_r <= 1'b0;
    end else begin
      esc_pending_r <= esc_pending_nxt;
    end
  end

endmodule

### design/efr_fifo.sv
// ----------------------------------------------------------------------------
// efr_fifo
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module efr_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  efr_pkg::efr_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output efr_pkg::efr_entry_t pop_entry
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [PW-1:0] PTR_ONE = PW'(1);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  efr_pkg::efr_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_ONE;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_ONE;
      end
    end
  end

endmodule

### design/efr_back.sv
// ----------------------------------------------------------------------------
// efr_back
// Runs the CRC-8, holds each data byte back by one, and emits payload bytes
// and end of frame markers through an output register.
// ----------------------------------------------------------------------------
module efr_back (
  input  logic                clk,
  input  logic                rst_n,
  // queue pop side
  input  logic                pop_valid,
  output logic                pop_ready,
  input  efr_pkg::efr_entry_t pop_entry,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [7:0]          out_byte,
  output logic                out_good
);

  logic       held_valid_r;
  logic       held_valid_nxt;
  logic [7:0] held_byte_r;
  logic [7:0] crc_r;
  logic [7:0] crc_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_good_r;
  logic       emit;
  logic       pop;
  logic       pop_end;
  logic       pop_data;

  // take a command whenever the output register is free or draining
  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign pop_end   = pop && (pop_entry.cmd == efr_pkg::CMD_END);
  assign pop_data  = pop && (pop_entry.cmd == efr_pkg::CMD_DATA);

  // a result only when a byte is held
  assign emit = pop && held_valid_r;

  // frame state next values
  always_comb begin
    held_valid_nxt = held_valid_r;
    crc_nxt        = crc_r;
    if (pop_end) begin
      held_valid_nxt = 1'b0;
      crc_nxt        = '0;
    end else if (pop_data) begin
      held_valid_nxt = 1'b1;
      crc_nxt        = efr_pkg::crc8_update(crc_r, pop_entry.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      crc_r        <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      crc_r        <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_data) begin
      held_byte_r <= pop_entry.data;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (pop_end) begin
        out_kind_r <= efr_pkg::ITEM_END;
        out_byte_r <= '0;
        out_good_r <= (crc_r == '0);
      end else begin
        out_kind_r <= efr_pkg::ITEM_PAYLOAD;
        out_byte_r <= held_byte_r;
        out_good_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_good  = out_good_r;

  // a payload result never carries a good flag, an end marker never a byte
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == efr_pkg::ITEM_PAYLOAD) ? !out_good_r
                                                           : (out_byte_r == '0)))
    else $error("result fields inconsistent with item kind");

  // closing a frame empties it and clears the crc
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop_end |=> (!held_valid_r && (crc_r == '0)))
    else $error("frame state not cleared at delimiter");

  // a data byte always leaves a held byte behind
  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    pop_data |=> held_valid_r)
    else $error("data byte not held");

  // a held result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("result register overwritten while stalled");

endmodule

### design/escaped_frame_receiver_crc8_core.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc8_core
// Byte-stuffed frame receiver with a per-frame reflected CRC-8 check.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+-----------------------------------
//   in_if   | sink      | valid / ready | rx_byte[7:0]
//   out_if  | source    | valid / ready | item_kind, payload_byte[7:0], crc_good
//   cfg_*   | sink      | cfg_we        | cfg_index (0 frame, 1 escape), cfg_data
//
// One line byte per cycle is taken while the queue has room; a result leaves via the
// queue and the output register once the next data byte or delimiter is popped.
// Reset (rst_n low, synchronous) empties the queue, the frame and the output.
// The queue holds QUEUE_DEPTH commands, so input stalls only once the output
// has been stalled long enough to fill it.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc8_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  efr_in_if.sink      in_if,
  efr_out_if.source   out_if
);

  logic                push_valid;
  logic                push_ready;
  efr_pkg::efr_entry_t push_entry;
  logic                pop_valid;
  logic                pop_ready;
  efr_pkg::efr_entry_t pop_entry;

  // classify and unescape
  efr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_byte    (in_if.rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // command queue
  efr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // crc, hold-back and result output
  efr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_kind  (out_if.item_kind),
    .out_byte  (out_if.payload_byte),
    .out_good  (out_if.crc_good)
  );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the escaped frame receiver against a behavioural model of its own.
// Line bytes are sent as well-formed stuffed frames with random content,
// broken frames and loose noise, under several delimiter and escape settings.
// Every result transaction is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 64;
  localparam int HOLD_AFTER     = 120;
  localparam int PHASE_ITEMS    = 270;
  localparam int MAX_REPORTS    = 40;

  // ways of spoiling a generated frame
  typedef enum int {
    FLAW_NONE     = 0,
    FLAW_CRC      = 1,
    FLAW_NO_DELIM = 2,
    FLAW_DATA     = 3,
    FLAW_ESC_TAIL = 4
  } frame_flaw_t;

  // predicted deframer state and the results still owed by the block
  class frame_scoreboard;
    typedef struct {
      efr_pkg::efr_item_t kind;
      logic [7:0]         payload;
      logic               crc_good;
    } frame_result_t;

    frame_result_t expected_q[$];
    logic [7:0]    frame_val;
    logic [7:0]    escape_val;
    logic [7:0]    crc_acc;
    logic [7:0]    held_byte;
    bit            escape_armed;
    bit            held_ok;
    int            errors;
    int            results_seen;

    function new();
      frame_val    = efr_pkg::FRAME_BYTE_RST;
      escape_val   = efr_pkg::ESCAPE_BYTE_RST;
      crc_acc      = 8'h00;
      held_byte    = 8'h00;
      escape_armed = 1'b0;
      held_ok      = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // bit-serial reflected crc-8, least significant bit first
    static function logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
        if (acc[0] ^ b[i]) begin
          acc = (acc >> 1) ^ efr_pkg::CRC_POLY;
        end else begin
          acc = acc >> 1;
        end
      end
      return acc;
    endfunction

    function void write_reg(input logic idx, input logic [7:0] v);
      if (idx == efr_pkg::CFG_FRAME_BYTE) begin
        frame_val = v;
      end else begin
        escape_val = v;
      end
    endfunction

    // one accepted line byte: update state, queue any result it causes
    function void note_rx(input logic [7:0] b);
      frame_result_t r;
      logic [7:0]    c;
      if (b == frame_val) begin
        // delimiter wins over escape; an empty frame is ignored
        if (held_ok) begin
          r.kind     = efr_pkg::ITEM_END;
          r.payload  = 8'h00;
          r.crc_good = (crc_acc == 8'h00);
          expected_q.push_back(r);
          held_ok   = 1'b0;
          held_byte = 8'h00;
          crc_acc   = 8'h00;
        end
      end else if (b == escape_val) begin
        escape_armed = 1'b1;
      end else begin
        c            = escape_armed ? (b ^ efr_pkg::ESC_XOR) : b;
        escape_armed = 1'b0;
        crc_acc      = crc8_step(crc_acc, c);
        // the previous data byte is released only now
        if (held_ok) begin
          r.kind     = efr_pkg::ITEM_PAYLOAD;
          r.payload  = held_byte;
          r.crc_good = 1'b0;
          expected_q.push_back(r);
        end
        held_byte = c;
        held_ok   = 1'b1;
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t ns mismatch: %s", $time, msg);
      end
    endtask

    // one accepted result transaction against the oldest prediction
    task check_result(input logic kind, input logic [7:0] payload, input logic good);
      frame_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0b byte %02h", kind, payload));
        return;
      end
      e = expected_q.pop_front();
      if (kind !== logic'(e.kind)) begin
        report($sformatf("item_kind %0b, predicted %0b", kind, e.kind));
      end
      if (payload !== e.payload) begin
        report($sformatf("payload_byte %02h, predicted %02h", payload, e.payload));
      end
      if (good !== e.crc_good) begin
        report($sformatf("crc_good %0b, predicted %0b", good, e.crc_good));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  efr_in_if  in_ch();
  efr_out_if out_ch();

  escaped_frame_receiver_crc8_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  frame_scoreboard sb = new();

  int bytes_sent  = 0;
  int idle_cycles = 0;
  int tx_calm     = 0;
  int rx_calm     = 0;
  bit fill_burst  = 1'b0;
  bit held_off    = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gap length: mostly none, some short, a few long, now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // random byte, biased towards the control values of the current setting
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return sb.frame_val;
      1: return sb.escape_val;
      2: return sb.frame_val ^ efr_pkg::ESC_XOR;
      3: return sb.escape_val ^ efr_pkg::ESC_XOR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // transaction monitor, scoreboard feed and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.item_kind, out_ch.payload_byte, out_ch.crc_good);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_rx(in_ch.rx_byte);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side ready, with one long hold-off to back the block up
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb.results_seen >= HOLD_AFTER) begin
        fill_burst   = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        fill_burst = 1'b0;
        held_off   = 1'b1;
      end
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left   = pick_gap(rx_calm);
      end
    end
  end

  // offer one line byte and wait until it is taken
  task automatic send_rx(input logic [7:0] b);
    int gap;
    gap = fill_burst ? 0 : pick_gap(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic tx_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // append the crc, stuff control values, close with a delimiter unless the flaw omits it
  task automatic send_frame(input logic [7:0] data[$], input frame_flaw_t flaw);
    logic [7:0] crc;
    int         idx;
    crc = 8'h00;
    foreach (data[i]) crc = frame_scoreboard::crc8_step(crc, data[i]);
    if (flaw == FLAW_CRC) begin
      crc = crc ^ (8'h01 << $urandom_range(0, 7));
    end
    data.push_back(crc);
    if (flaw == FLAW_DATA) begin
      idx       = $urandom_range(0, data.size() - 1);
      data[idx] = data[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (data[i]) begin
      if (data[i] == sb.frame_val || data[i] == sb.escape_val) begin
        send_rx(sb.escape_val);
        send_rx(data[i] ^ efr_pkg::ESC_XOR);
      end else begin
        send_rx(data[i]);
      end
    end
    if (flaw == FLAW_ESC_TAIL) begin
      send_rx(sb.escape_val);
    end
    if (flaw != FLAW_NO_DELIM) begin
      send_rx(sb.frame_val);
    end
  endtask

  // mostly short frames, now and then a longer one
  task automatic random_frame(input frame_flaw_t flaw);
    logic [7:0] data[$];
    int         len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    repeat (len) data.push_back(pick_byte());
    send_frame(data, flaw);
  endtask

  task automatic run_random(input int count);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        random_frame(FLAW_NONE);
      end else if (r < 90) begin
        random_frame(frame_flaw_t'($urandom_range(FLAW_CRC, FLAW_ESC_TAIL)));
      end else begin
        repeat ($urandom_range(1, 6)) send_rx(pick_byte());
      end
    end
    tx_idle();
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, v);
  endtask

  // drain all owed results and let the pipeline empty before the setting changes
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] fb, input logic [7:0] eb);
    drain();
    cfg_write(efr_pkg::CFG_FRAME_BYTE, fb);
    cfg_write(efr_pkg::CFG_ESCAPE_BYTE, eb);
  endtask

  // stimulus
  initial begin
    logic [7:0] raw[$];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = efr_pkg::CFG_FRAME_BYTE;
    cfg_data      = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // delimiter on an empty frame, then a good frame with extreme bytes
    send_rx(efr_pkg::FRAME_BYTE_RST);
    send_frame({8'h00, 8'hFF}, FLAW_NONE);
    // payload that needs stuffing of both control values
    send_frame({efr_pkg::FRAME_BYTE_RST, efr_pkg::ESCAPE_BYTE_RST, 8'h7E}, FLAW_NONE);
    // double escape, then an escape left pending across a closing delimiter
    raw = {efr_pkg::ESCAPE_BYTE_RST, efr_pkg::ESCAPE_BYTE_RST, 8'h41,
           efr_pkg::FRAME_BYTE_RST, 8'h11, efr_pkg::ESCAPE_BYTE_RST,
           efr_pkg::FRAME_BYTE_RST, 8'h30, efr_pkg::FRAME_BYTE_RST};
    foreach (raw[i]) send_rx(raw[i]);
    // bad crc
    send_frame({8'h80}, FLAW_CRC);
    tx_idle();

    run_random(PHASE_ITEMS);
    reconfigure(8'h00, 8'hFF);
    run_random(PHASE_ITEMS);
    reconfigure(8'hFF, 8'h00);
    run_random(PHASE_ITEMS);
    reconfigure(8'h7E, 8'h7D);
    run_random(PHASE_ITEMS);
    // delimiter and escape share a value
    reconfigure(8'h55, 8'h55);
    run_random(PHASE_ITEMS);
    reconfigure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(PHASE_ITEMS);

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### escaped_frame_receiver_crc8_core.f
design/efr_pkg.sv
design/efr_in_if.sv
design/efr_out_if.sv
design/efr_front.sv
design/efr_fifo.sv
design/efr_back.sv
design/escaped_frame_receiver_crc8_core.sv
test/testbench.sv
